@@ src/tccw_pkg.sv @@
package tccw_pkg;

  localparam int CELLS_MAX = 16384;
  localparam int CELL_AW   = $clog2(CELLS_MAX);
  localparam int CNT_W     = CELL_AW + 1;
  localparam int CELL_W    = 16;
  localparam int DIV_CW    = $clog2(CELL_AW);
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_SPACE     = 8'd32;
  localparam logic [7:0] ATTR_BLANK   = 8'h0F;
  localparam logic [CELL_W-1:0] BLANK_CELL = {ATTR_BLANK, CH_SPACE};

  localparam logic [7:0] COLS_RESET = 8'd80;
  localparam logic [7:0] ROWS_RESET = 8'd25;
  localparam logic [7:0] DIM_MAX    = 8'd128;

  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  localparam logic OP_PRINT = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SCROLLED  = 2'd1;
  localparam logic [1:0] ST_OFFSCREEN = 2'd2;

  localparam logic [1:0] KIND_CHAR      = 2'd0;
  localparam logic [1:0] KIND_NEWLINE   = 2'd1;
  localparam logic [1:0] KIND_BACKSPACE = 2'd2;
  localparam logic [1:0] KIND_CLEAR     = 2'd3;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  char_code;
    logic [7:0]  attribute;
    logic        at_cursor;
    logic [13:0] position;
  } in_word_t;

  typedef struct packed {
    logic [13:0] cursor_cell;
    logic [1:0]  status;
  } out_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  char_code;
    logic [7:0]  attribute;
    logic        at_cursor;
    logic [13:0] position;
  } cmd_t;

  typedef struct packed {
    logic [7:0]       cols;
    logic [CNT_W-1:0] cells;
  } geom_t;

endpackage

@@ src/text_console_char_writer.sv @@
// Text console character writer. Words on the in_ channel print one character at the cursor
// or at a given cell, or clear the screen; each word returns one result with the new cursor
// cell and a status (ok, scrolled, off screen). A two-entry queue sits between the input
// and the cell engine, so up to three more words are taken while a result waits on the out_
// channel (one held by the engine, two in the queue).
// A character or backspace passes S_EXEC and S_CHECK, a position off screen goes from S_EXEC
// to S_DONE, and a newline first finds the row start in a one-bit-per-cycle remainder unit.
// When the screen scrolls, rows move up through the one cell buffer port, one cell a cycle,
// and the last row is blanked; a clear blanks every screen cell. After reset a clearing pass
// blanks all 16384 cells, one a cycle, and in_ready stays low until it ends. Configuration
// writes reach cols_r/rows_r, then geom_r, and are to be made only while the block is idle.
module text_console_char_writer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tccw_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output tccw_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data
);
  import tccw_pkg::*;

  logic [7:0] cols_r, cols_nxt;
  logic [7:0] rows_r, rows_nxt;
  geom_t      geom_r, geom_nxt;
  logic [7:0] eff_cols;
  logic [7:0] eff_rows;
  logic       init_done;
  logic       q_valid;
  cmd_t       q_cmd;
  logic       q_pop;

  always_comb begin
    cols_nxt = cols_r;
    rows_nxt = rows_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_COLUMNS: cols_nxt = cfg_data;
        REG_ROWS:    rows_nxt = cfg_data;
        default:     cols_nxt = cols_r;
      endcase
    end
  end

  // clamp to 1..128; 128 x 128 never exceeds the buffer
  always_comb begin
    if (cols_r == '0) begin
      eff_cols = 8'd1;
    end else if (cols_r > DIM_MAX) begin
      eff_cols = DIM_MAX;
    end else begin
      eff_cols = cols_r;
    end
    if (rows_r == '0) begin
      eff_rows = 8'd1;
    end else if (rows_r > DIM_MAX) begin
      eff_rows = DIM_MAX;
    end else begin
      eff_rows = rows_r;
    end
    geom_nxt.cols  = eff_cols;
    geom_nxt.cells = CNT_W'(16'(eff_cols) * 16'(eff_rows));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COLS_RESET;
      rows_r <= ROWS_RESET;
      geom_r <= '{cols: COLS_RESET, cells: CNT_W'(16'(COLS_RESET) * 16'(ROWS_RESET))};
    end else begin
      cols_r <= cols_nxt;
      rows_r <= rows_nxt;
      geom_r <= geom_nxt;
    end
  end

  tccw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .enable   (init_done),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  tccw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom_r),
    .init_done (init_done),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

@@ src/tccw_ram.sv @@
module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/tccw_front.sv @@
module tccw_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               enable,
  input  logic               in_valid,
  output logic               in_ready,
  input  tccw_pkg::in_word_t in_word,
  output logic               q_valid,
  output tccw_pkg::cmd_t     q_cmd,
  input  logic               q_pop
);
  import tccw_pkg::*;

  cmd_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  cmd_t              cmd_in;
  logic              push;
  logic              pop;

  // classify the word
  always_comb begin
    cmd_in.char_code = in_word.char_code;
    cmd_in.attribute = in_word.attribute;
    cmd_in.at_cursor = in_word.at_cursor;
    cmd_in.position  = in_word.position;
    if (in_word.opcode == OP_CLEAR) begin
      cmd_in.kind = KIND_CLEAR;
    end else if (in_word.char_code == CH_NEWLINE) begin
      cmd_in.kind = KIND_NEWLINE;
    end else if (in_word.char_code == CH_BACKSPACE) begin
      cmd_in.kind = KIND_BACKSPACE;
    end else begin
      cmd_in.kind = KIND_CHAR;
    end
  end

  assign q_valid  = (count_r != '0);
  assign in_ready = enable && (count_r != QCNT_W'(QDEPTH));
  assign q_cmd    = q_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

@@ src/tccw_back.sv @@
module tccw_back (
  input  logic                clk,
  input  logic                rst_n,
  input  tccw_pkg::geom_t     geom,
  output logic                init_done,
  input  logic                q_valid,
  input  tccw_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output tccw_pkg::out_word_t out_word
);
  import tccw_pkg::*;

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_EXEC   = 4'd2;
  localparam logic [3:0] S_DIV    = 4'd3;
  localparam logic [3:0] S_ROWEND = 4'd4;
  localparam logic [3:0] S_CHECK  = 4'd5;
  localparam logic [3:0] S_COPY   = 4'd6;
  localparam logic [3:0] S_BLANK  = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DIV_CW-1:0]  div_cnt_r, div_cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [13:0]        cursor_r, cursor_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [CNT_W-1:0]   off_r, off_nxt;
  logic [CNT_W-1:0]   noff_r, noff_nxt;
  logic [CELL_AW-1:0] dvd_r, dvd_nxt;
  logic [7:0]         rem_r, rem_nxt;
  logic [13:0]        res_cursor_r, res_cursor_nxt;
  logic [1:0]         res_status_r, res_status_nxt;
  out_word_t          out_word_r, out_word_nxt;

  logic               ram_we;
  logic [CELL_AW-1:0] ram_waddr;
  logic [CELL_W-1:0]  ram_wdata;
  logic [CELL_AW-1:0] ram_raddr;
  logic [CELL_W-1:0]  ram_rdata;

  logic [8:0]         div_tmp;
  logic [CNT_W-1:0]   copy_last;
  logic [CNT_W-1:0]   cols_w;
  logic [CNT_W-1:0]   cnt_dec;
  logic [CNT_W-1:0]   raddr_w;

  tccw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS_MAX)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign init_done = (state_r != S_INIT);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign cols_w    = CNT_W'(geom.cols);
  assign copy_last = geom.cells - cols_w;
  assign cnt_dec   = cnt_r - 1'b1;
  assign raddr_w   = cnt_r + cols_w;
  assign div_tmp   = {rem_r, dvd_r[CELL_AW-1]};

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    div_cnt_nxt    = div_cnt_r;
    out_valid_nxt  = out_valid_r;
    cursor_nxt     = cursor_r;
    cmd_nxt        = cmd_r;
    off_nxt        = off_r;
    noff_nxt       = noff_r;
    dvd_nxt        = dvd_r;
    rem_nxt        = rem_r;
    res_cursor_nxt = res_cursor_r;
    res_status_nxt = res_status_r;
    out_word_nxt   = out_word_r;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = cnt_r[CELL_AW-1:0];
    ram_wdata      = BLANK_CELL;
    ram_raddr      = raddr_w[CELL_AW-1:0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_INIT: begin
        ram_we = 1'b1;
        if (cnt_r == CNT_W'(CELLS_MAX - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_cmd;
          off_nxt   = q_cmd.at_cursor ? CNT_W'(cursor_r) : CNT_W'(q_cmd.position);
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd_r.kind == KIND_CLEAR) begin
          cnt_nxt   = '0;
          state_nxt = S_BLANK;
        end else if (off_r >= geom.cells) begin
          res_cursor_nxt = cursor_r;
          res_status_nxt = ST_OFFSCREEN;
          state_nxt      = S_DONE;
        end else begin
          case (cmd_r.kind)
            KIND_NEWLINE: begin
              dvd_nxt     = off_r[CELL_AW-1:0];
              rem_nxt     = '0;
              div_cnt_nxt = '0;
              state_nxt   = S_DIV;
            end
            KIND_BACKSPACE: begin
              noff_nxt  = (off_r == '0) ? '0 : off_r - 1'b1;
              state_nxt = S_CHECK;
            end
            default: begin
              ram_we    = 1'b1;
              ram_waddr = off_r[CELL_AW-1:0];
              ram_wdata = {cmd_r.attribute, cmd_r.char_code};
              noff_nxt  = off_r + 1'b1;
              state_nxt = S_CHECK;
            end
          endcase
        end
      end
      // restoring remainder, one dividend bit a cycle
      S_DIV: begin
        if (div_tmp >= {1'b0, geom.cols}) begin
          rem_nxt = 8'(div_tmp - {1'b0, geom.cols});
        end else begin
          rem_nxt = div_tmp[7:0];
        end
        dvd_nxt     = {dvd_r[CELL_AW-2:0], 1'b0};
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == DIV_CW'(CELL_AW - 1)) begin
          state_nxt = S_ROWEND;
        end
      end
      S_ROWEND: begin
        noff_nxt  = off_r - CNT_W'(rem_r) + cols_w;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (noff_r >= geom.cells) begin
          cnt_nxt   = '0;
          state_nxt = S_COPY;
        end else begin
          res_cursor_nxt = noff_r[13:0];
          res_status_nxt = ST_OK;
          state_nxt      = S_DONE;
        end
      end
      // read one row ahead, write the word read last cycle
      S_COPY: begin
        if (cnt_r != '0) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_dec[CELL_AW-1:0];
          ram_wdata = ram_rdata;
        end
        if (cnt_r == copy_last) begin
          state_nxt = S_BLANK;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_BLANK: begin
        ram_we = 1'b1;
        if (cnt_r == geom.cells - 1'b1) begin
          if (cmd_r.kind == KIND_CLEAR) begin
            res_cursor_nxt = '0;
            res_status_nxt = ST_OK;
          end else begin
            res_cursor_nxt = (noff_r >= cols_w) ? 14'(noff_r - cols_w) : '0;
            res_status_nxt = ST_SCROLLED;
          end
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_word_nxt.cursor_cell = res_cursor_r;
          out_word_nxt.status      = res_status_r;
          cursor_nxt               = res_cursor_r;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= '0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      cursor_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      cursor_r    <= cursor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    off_r        <= off_nxt;
    noff_r       <= noff_nxt;
    dvd_r        <= dvd_nxt;
    rem_r        <= rem_nxt;
    res_cursor_r <= res_cursor_nxt;
    res_status_r <= res_status_nxt;
    out_word_r   <= out_word_nxt;
  end

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ram_we)
    else $error("cell write while idle");

  a_pop_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_valid && state_r == S_IDLE))
    else $error("queue pop without a waiting word");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_ready) |=> (state_r == S_DONE))
    else $error("result overwritten before taken");

  a_blank_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BLANK) |-> (cnt_r < geom.cells))
    else $error("blank sweep past last cell");

  a_copy_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COPY) |-> (cnt_r <= copy_last))
    else $error("scroll copy past last row");

endmodule
